FILE: hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Window size register width is fixed by the register map.
  localparam int CFG_W = 7;

  typedef logic [CFG_W-1:0] cfg_word_t;

  // Per-cell step control, fanned out from the top level.
  typedef struct packed {
    logic step;       // a word is accepted this cycle
    logic restart;    // the accepted word starts a new stream
    logic in_window;  // this cell's index lies below the effective window
    logic head;       // cell 0: always takes the new sample
  } swm_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/swm_if.sv
`default_nettype none

interface swm_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

FILE: hdl/sliding_window_max_unit.sv
`default_nettype none

// Channel   | Dir | Payload                        | Handshake
// ----------+-----+--------------------------------+---------------------------
// in_chan   | in  | sample (signed), restart       | valid/ready, 1/clk if ready
// out_chan  | out | window_max (signed)            | valid/ready, 0 or 1 per in
// cfg_*     | in  | cfg_wdata = window_size (7 b)  | cfg_we, write only
//
// One input word per cycle while in_chan.ready is high. Every cell of the row
// compares the new sample with its neighbor's running max in the same cycle;
// the result goes to the output register, or to the skid stage if that is held.
// Reset (rst_n low, synchronous) empties the row, zeroes the sample count and
// sets window_size to 1. A one-word skid stage behind the output register lets
// one more word in while out_chan is stalled; in_chan.ready drops only when
// both are full.

module sliding_window_max_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  swm_in_if.sink               in_chan,
  swm_out_if.source            out_chan,
  input  wire logic            cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Count width holds WINDOW_MAX itself; compare width covers both the
  // register and the count.
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  cfg_word_t                     win_size_r;
  logic [EXT_W-1:0]              win_ext;
  logic [EXT_W-1:0]              win_eff;

  logic [CNT_W-1:0]              seen_r;
  logic [CNT_W-1:0]              seen_base;
  logic [CNT_W-1:0]              seen_nxt;

  logic                          accept;
  logic                          result_hit;
  logic                          push;
  logic                          pop;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          skid_valid_r;
  logic signed [SAMPLE_BITS-1:0] skid_data_r;

  // cell row
  logic [WINDOW_MAX-1:0]         valid_r_v;
  logic [WINDOW_MAX-1:0]         valid_nxt_v;
  logic [WINDOW_MAX-1:0]         is_top;
  logic signed [SAMPLE_BITS-1:0] value_r_a   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] value_nxt_a [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] max_sel;

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign in_chan.ready       = !skid_valid_r;
  assign accept              = in_chan.valid && !skid_valid_r;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.window_max = out_data_r;
  assign pop                 = out_valid_r && out_chan.ready;
  assign push                = accept && result_hit;

  // ---------------------------------------------------------------------
  // Window size: zero acts as 1, anything above the row length is clipped.
  // ---------------------------------------------------------------------
  assign win_ext = EXT_W'(win_size_r);

  always_comb begin
    if (win_size_r == '0) begin
      win_eff = EXT_W'(1);
    end else if (win_ext > EXT_W'(WINDOW_MAX)) begin
      win_eff = EXT_W'(WINDOW_MAX);
    end else begin
      win_eff = win_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= cfg_word_t'(1);
    end else if (cfg_we) begin
      win_size_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Samples seen in the current stream, saturating at the row length.
  // A result goes out once a full window has arrived.
  // ---------------------------------------------------------------------
  assign seen_base  = in_chan.restart ? '0 : seen_r;
  assign seen_nxt   = (seen_base == CNT_W'(WINDOW_MAX)) ? seen_base
                                                        : seen_base + CNT_W'(1);
  assign result_hit = EXT_W'(seen_nxt) >= win_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row. Cell i keeps the max of the retained samples aged 0..i.
  // A sample's share moves one cell right per word; it is lost once its
  // cell falls outside the window, which is exactly when the deque would
  // drop it. Valid cells always form a prefix, and the last valid cell
  // holds the max of every retained sample.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_ctrl_t                     ctrl;
    logic                          prev_valid;
    logic signed [SAMPLE_BITS-1:0] prev_value;

    assign ctrl.step      = accept;
    assign ctrl.restart   = in_chan.restart;
    assign ctrl.in_window = EXT_W'(g) < win_eff;
    assign ctrl.head      = (g == 0);

    if (g == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_value = in_chan.sample;
    end else begin : g_link
      assign prev_valid = valid_r_v[g-1];
      assign prev_value = value_r_a[g-1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sample     (in_chan.sample),
      .prev_valid (prev_valid),
      .prev_value (prev_value),
      .valid_r    (valid_r_v[g]),
      .value_r    (value_r_a[g]),
      .valid_nxt  (valid_nxt_v[g]),
      .value_nxt  (value_nxt_a[g])
    );
  end

  // Last valid cell after this step is the front of the deque.
  assign is_top = valid_nxt_v & ~(valid_nxt_v >> 1);

  always_comb begin
    max_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (is_top[i]) begin
        max_sel = max_sel | value_nxt_a[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register plus one-word skid.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= max_sel;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_data_r <= max_sel;
      end else begin
        skid_data_r <= max_sel;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swm_cell.sv
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swm_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          prev_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_value,
  output logic                               valid_r,
  output logic signed [SAMPLE_BITS-1:0]      value_r,
  output logic                               valid_nxt,
  output logic signed [SAMPLE_BITS-1:0]      value_nxt
);

  logic keep_prev;

  // Cell i holds the max of retained samples aged 0..i; it inherits its
  // left neighbor's running max and folds in the new sample.
  assign keep_prev = prev_valid && !ctrl.restart && (prev_value > sample);
  assign valid_nxt = ctrl.in_window && (ctrl.head || (prev_valid && !ctrl.restart));
  assign value_nxt = keep_prev ? prev_value : sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value_r <= value_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_sliding_window_max_unit.sv
`timescale 1ns / 1ps

module tb_sliding_window_max_unit;
  import swm_pkg::*;

  localparam int WIN_MAX      = 64;
  localparam int SMP_W        = 32;
  localparam int N_DIR        = 24;
  localparam int N_RANDOM     = 1200;
  localparam int SETTLE_CYC   = 4;      // output reg + skid, with margin
  localparam int LIMIT_CYCLES = 400000;
  localparam int EXP_DEPTH    = 256;    // ring of expected words, far above what is in flight

  localparam logic signed [SMP_W-1:0] SMP_MIN = 32'sh8000_0000;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 32'sh7FFF_FFFF;

  // Flow-control profile of the current phase.
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  // Shape of the random sample stream within one segment.
  typedef enum int {
    SHAPE_FULL, SHAPE_NARROW, SHAPE_RAMP_UP, SHAPE_RAMP_DOWN, SHAPE_EDGES
  } sample_shape_t;

  // One row of the directed table. typed = expected max given in the row.
  typedef struct packed {
    logic [CFG_W-1:0]          win;
    logic signed [SMP_W-1:0]   smp;
    logic                      rst;
    logic                      typed;
    logic signed [SMP_W-1:0]   exp_val;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  swm_in_if  #(.SAMPLE_BITS(SMP_W)) in_chan ();
  swm_out_if #(.SAMPLE_BITS(SMP_W)) out_chan ();

  sliding_window_max_unit #(
    .WINDOW_MAX  (WIN_MAX),
    .SAMPLE_BITS (SMP_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: monotone deque of candidate maxima, front = cell 0.
  // Only the first dq_depth cells are live.
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] dq_val [WIN_MAX];
  int unsigned             dq_age [WIN_MAX];
  int unsigned             dq_depth   = 0;
  int unsigned             stream_len = 0;   // samples of the current stream, saturating
  logic [CFG_W-1:0]        win_reg    = 7'd1; // window_size as the block holds it

  // Expected window maxima, oldest at exp_rd. Write side owned by the sender,
  // read side by the checker.
  logic signed [SMP_W-1:0] exp_max_q [EXP_DEPTH];
  logic [8:0]              exp_wr    = '0;
  logic [8:0]              exp_rd    = '0;
  int unsigned             err_count = 0;
  idle_mode_t              idle_mode = IDLE_NONE;

  // Directed table. Extremes, zero window, clamp above 64, equal values,
  // shrink and grow mid-stream, restart. Plain rows go through the predictor.
  dir_row_t dir_tbl [N_DIR] = '{
    // reset window of 1: result is the sample itself
    '{7'd1,   32'sd5,         1'b0, 1'b1, 32'sd5},
    '{7'd1,   SMP_MIN,        1'b0, 1'b1, SMP_MIN},
    '{7'd1,   SMP_MAX,        1'b0, 1'b1, SMP_MAX},
    '{7'd1,   32'sd0,         1'b1, 1'b1, 32'sd0},
    // window size zero behaves as one
    '{7'd0,   -32'sd7,        1'b1, 1'b1, -32'sd7},
    '{7'd0,   32'sd100,       1'b0, 1'b1, 32'sd100},
    // window of 3, no result until the third word
    '{7'd3,   32'sd1,         1'b1, 1'b0, 32'sd0},
    '{7'd3,   32'sd3,         1'b0, 1'b0, 32'sd0},
    '{7'd3,   32'sd2,         1'b0, 1'b1, 32'sd3},
    '{7'd3,   32'sd1,         1'b0, 1'b1, 32'sd3},
    '{7'd3,   32'sd0,         1'b0, 1'b1, 32'sd2},
    '{7'd3,   -32'sd5,        1'b0, 1'b1, 32'sd1},
    '{7'd3,   32'sd7,         1'b1, 1'b0, 32'sd0},
    // shrink to 2 mid-stream, then equal values
    '{7'd2,   -32'sd9,        1'b0, 1'b0, 32'sd0},
    '{7'd2,   -32'sd9,        1'b0, 1'b1, -32'sd9},
    '{7'd2,   SMP_MIN,        1'b0, 1'b1, -32'sd9},
    '{7'd2,   SMP_MIN,        1'b0, 1'b1, SMP_MIN},
    // grow to 5 mid-stream: only retained samples count
    '{7'd5,   32'sd3,         1'b0, 1'b0, 32'sd0},
    '{7'd5,   32'sd2,         1'b0, 1'b0, 32'sd0},
    // 127 clamps to 64; then an exact 64
    '{7'd127, 32'sd4,         1'b1, 1'b0, 32'sd0},
    '{7'd127, SMP_MAX,        1'b0, 1'b0, 32'sd0},
    '{7'd64,  32'sd9,         1'b0, 1'b0, 32'sd0},
    // shrink 64 -> 1 mid-stream
    '{7'd1,   SMP_MAX,        1'b0, 1'b1, SMP_MAX},
    '{7'd1,   SMP_MIN,        1'b0, 1'b1, SMP_MIN}
  };

  // Number of expected words not yet seen on out_chan.
  function automatic logic [8:0] exp_pending();
    return 9'(exp_wr - exp_rd);
  endfunction

  // Append one expected word to the ring.
  task automatic queue_expected(input logic signed [SMP_W-1:0] v);
    exp_max_q[exp_wr[7:0]] = v;
    exp_wr = 9'(exp_wr + 9'd1);
  endtask

  // Deque update for one accepted word; has = a result is due.
  task automatic predict_window_max(input logic signed [SMP_W-1:0] s, input logic restart,
                                    output bit has, output logic signed [SMP_W-1:0] mx);
    int unsigned w;
    int unsigned drop;
    w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
    if (restart) begin
      dq_depth   = 0;
      stream_len = 0;
    end
    // age everything, then retire front entries that fell out of the window
    for (int i = 0; i < dq_depth; i++)
      if (dq_age[i] < WIN_MAX) dq_age[i]++;
    drop = 0;
    while (drop < dq_depth && dq_age[drop] >= w) drop++;
    if (drop > 0) begin
      for (int i = 0; i < dq_depth - drop; i++) begin
        dq_val[i] = dq_val[i + drop];
        dq_age[i] = dq_age[i + drop];
      end
      dq_depth -= drop;
    end
    // newer sample beats any older one that is not larger (ties included)
    while (dq_depth > 0 && dq_val[dq_depth - 1] <= s) dq_depth--;
    if (dq_depth < WIN_MAX) begin
      dq_val[dq_depth] = s;
      dq_age[dq_depth] = 0;
      dq_depth++;
    end
    if (stream_len < WIN_MAX) stream_len++;
    has = (stream_len >= w);
    mx  = dq_val[0];
  endtask

  // Present one word, wait for acceptance, queue its expected max.
  task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic restart,
                             input logic typed, input logic signed [SMP_W-1:0] typed_max);
    bit                      has;
    logic signed [SMP_W-1:0] mx;
    while ((idle_mode == IDLE_SRC && $urandom_range(0, 99) < 49) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9)) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.sample  <= s;
    in_chan.restart <= restart;
    do @(posedge clk); while (!in_chan.ready);
    predict_window_max(s, restart, has, mx);
    if (typed) queue_expected(typed_max);
    else if (has) queue_expected(mx);
  endtask

  // Stop sending and let every pending word come out.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (exp_pending() != 9'd0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    win_reg = w;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_window();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 12) return CFG_W'($urandom_range(1, 8));
    if (k < 16) return CFG_W'($urandom_range(9, 40));
    if (k < 18) return CFG_W'($urandom_range(41, 64));
    if (k == 18) return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd127;
    return CFG_W'($urandom_range(65, 127));
  endfunction

  function automatic logic signed [SMP_W-1:0] next_sample(input sample_shape_t shp,
                                                          input logic signed [SMP_W-1:0] prev);
    logic signed [SMP_W-1:0] v;
    v = $urandom();
    // a sprinkle of fully random words in every shape
    if ($urandom_range(0, 99) < 15) return v;
    case (shp)
      SHAPE_NARROW:    v = int'($urandom_range(0, 6)) - 3;
      SHAPE_RAMP_UP:   v = prev + int'($urandom_range(0, 4));
      SHAPE_RAMP_DOWN: v = prev - int'($urandom_range(0, 4));
      SHAPE_EDGES: begin
        case ($urandom_range(0, 4))
          0: v = SMP_MIN;
          1: v = SMP_MAX;
          2: v = '0;
          3: v = -32'sd1;
          default: v = $urandom();
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure per phase, in-order compare.
  // ---------------------------------------------------------------------------
  initial begin
    in_chan.valid    = 1'b0;
    in_chan.sample   = '0;
    in_chan.restart  = 1'b0;
    out_chan.ready   = 1'b0;
  end

  always @(posedge clk) begin
    if (idle_mode == IDLE_SNK) begin
      out_chan.ready <= ($urandom_range(0, 99) >= 49);
    end else if (idle_mode == IDLE_BOTH) begin
      out_chan.ready <= ($urandom_range(0, 99) >= 9);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (exp_pending() == 9'd0) begin
        $display("%0t: unexpected word, window_max actual %0d", $time, out_chan.window_max);
        err_count++;
      end else begin
        if (out_chan.window_max !== exp_max_q[exp_rd[7:0]]) begin
          $display("%0t: window_max mismatch, expected %0d actual %0d",
                   $time, exp_max_q[exp_rd[7:0]], out_chan.window_max);
          err_count++;
        end
        exp_rd = 9'(exp_rd + 9'd1);
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0]        w;
    int unsigned             w_eff;
    int unsigned             seg_len;
    int unsigned             rst_pct;
    int unsigned             sent;
    int unsigned             seg_idx;
    sample_shape_t           shp;
    logic signed [SMP_W-1:0] smp;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no flow-control gaps. A window change in the table
    // means drain first, then write the register.
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].win != win_reg) begin
        drain_results();
        write_window(dir_tbl[i].win);
      end
      send_sample(dir_tbl[i].smp, dir_tbl[i].rst, dir_tbl[i].typed, dir_tbl[i].exp_val);
    end

    // Random segments: each picks a window, an idle profile and a stream shape.
    sent    = 0;
    seg_idx = 0;
    smp     = '0;
    while (sent < N_RANDOM) begin
      w     = pick_window();
      w_eff = (w == 0) ? 1 : ((w > WIN_MAX) ? WIN_MAX : w);
      if (w_eff <= 8) begin
        seg_len = $urandom_range(20, 60);
        rst_pct = 4;
      end else begin
        // long windows need long streams before any result
        seg_len = $urandom_range(w_eff + 20, 2 * w_eff + 60);
        rst_pct = 1;
      end
      // about half the segments keep the previous window, so streams run on
      drain_results();
      idle_mode = idle_mode_t'(seg_idx % 4);
      if (seg_idx == 0 || $urandom_range(0, 1) != 0) write_window(w);
      shp = sample_shape_t'($urandom_range(0, 4));
      for (int n = 0; n < seg_len; n++) begin
        smp = next_sample(shp, smp);
        send_sample(smp, ($urandom_range(0, 99) < rst_pct), 1'b0, '0);
        sent++;
      end
      seg_idx++;
    end

    drain_results();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
